// ===== rtl/bmv_pkg.sv =====
// Package for the banded matrix-vector product block.
// Holds sizes, codes, state encoding and the structs passed between modules.
// No dependencies.
`default_nettype none

package bmv_pkg;

    // Sizing of the stores and of the fixed-point format.
    localparam int MAX_LENGTH = 64;
    localparam int MAX_SIDE   = 7;
    localparam int FRAC_BITS  = 16;

    localparam int BAND_ROWS  = 2 * MAX_SIDE + 1;
    localparam int BAND_DEPTH = BAND_ROWS * MAX_LENGTH;
    localparam int BAND_AW    = $clog2(BAND_DEPTH);

    // Field widths.
    localparam int DATA_W     = 32;
    localparam int OP_W       = 2;
    localparam int BROW_W     = 4;
    localparam int POS_W      = 6;
    localparam int SIDE_W     = 3;
    localparam int LEN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Band step counter and signed column index widths.
    localparam int KW  = $clog2(BAND_ROWS);
    localparam int J_W = $clog2(MAX_LENGTH + 2 * MAX_SIDE + 1) + 1;

    // Wide accumulator: one full product plus growth for all terms and the base.
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(BAND_ROWS + 2) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_BAND   = 2'd0,
        OP_VECTOR = 2'd1,
        OP_ACCUM  = 2'd2,
        OP_RUN    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPPER  = 2'd0,
        REG_LOWER  = 2'd1,
        REG_LENGTH = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // One multiply-accumulate term as it travels down the pipeline.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             ok;
        logic [POS_W-1:0] row;
        logic             last_row;
    } term_t;

    // A finished row.
    typedef struct packed {
        logic                     valid;
        logic [POS_W-1:0]         row;
        logic signed [DATA_W-1:0] result;
        logic                     sat;
        logic                     last_row;
    } fin_t;

    // Memory port requests from the sequencer.
    typedef struct packed {
        logic               band_we;
        logic [BAND_AW-1:0] band_waddr;
        logic [DATA_W-1:0]  band_wdata;
        logic               band_re;
        logic [BAND_AW-1:0] band_raddr;
        logic               vec_we;
        logic [POS_W-1:0]   vec_waddr;
        logic [DATA_W-1:0]  vec_wdata;
        logic               vec_re;
        logic [POS_W-1:0]   vec_raddr;
        logic               acc_we;
        logic [POS_W-1:0]   acc_waddr;
        logic [DATA_W-1:0]  acc_wdata;
        logic               acc_re;
        logic [POS_W-1:0]   acc_raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/bmv_in_if.sv =====
// Input channel of the banded matrix-vector product block.
// Valid/ready handshake with the load and run item payload; uses bmv_pkg.
`default_nettype none

interface bmv_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [bmv_pkg::OP_W-1:0]              operation;
    logic [bmv_pkg::BROW_W-1:0]            band_row;
    logic [bmv_pkg::POS_W-1:0]             position;
    logic signed [bmv_pkg::DATA_W-1:0]     value;

    modport source (output valid, output operation, output band_row, output position,
                    output value, input ready);
    modport sink   (input valid, input operation, input band_row, input position,
                    input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmv_out_if.sv =====
// Output channel of the banded matrix-vector product block.
// Valid/ready handshake with one result element per transfer; uses bmv_pkg.
`default_nettype none

interface bmv_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [bmv_pkg::POS_W-1:0]             row_index;
    logic signed [bmv_pkg::DATA_W-1:0]     result;
    logic                                  saturated;
    logic                                  last;

    modport source (output valid, output row_index, output result, output saturated,
                    output last, input ready);
    modport sink   (input valid, input row_index, input result, input saturated,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmv_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bmv_ctrl.sv =====
// Sequencer of the banded matrix-vector product: configuration registers,
// load handling, row and band stepping, memory requests. Uses bmv_pkg, bmv_in_if.
`default_nettype none

module bmv_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bmv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bmv_pkg::CFG_DATA_W-1:0]    cfg_data,
    bmv_in_if.sink                                 in_ch,
    input  wire logic                              out_free,
    input  wire bmv_pkg::fin_t                     fin,
    output bmv_pkg::term_t                         issue,
    output bmv_pkg::mem_req_t                      mem,
    output logic                                   acc_ok
);

    bmv_pkg::state_t                    state_reg, state_next;
    logic [bmv_pkg::POS_W-1:0]          row_reg, row_next;
    logic [bmv_pkg::KW-1:0]             k_reg, k_next;
    logic [bmv_pkg::SIDE_W-1:0]         upper_reg, lower_reg;
    logic [bmv_pkg::LEN_W-1:0]          length_reg;
    logic [bmv_pkg::MAX_LENGTH-1:0]     acc_vld_reg;
    logic                               acc_ok_reg;

    logic [bmv_pkg::SIDE_W-1:0]         u_eff, l_eff;
    logic [bmv_pkg::LEN_W-1:0]          n_eff;
    logic [bmv_pkg::KW-1:0]             k_max;
    logic                               row_last;
    logic signed [bmv_pkg::J_W-1:0]     j;
    logic                               term_ok;
    logic                               in_fire;
    logic                               is_run;
    logic                               pos_ok;
    logic                               brow_ok;

    // Effective sizes, clamped to the store dimensions.
    always_comb
    begin
        u_eff = (upper_reg > bmv_pkg::SIDE_W'(bmv_pkg::MAX_SIDE)) ?
                bmv_pkg::SIDE_W'(bmv_pkg::MAX_SIDE) : upper_reg;
        l_eff = (lower_reg > bmv_pkg::SIDE_W'(bmv_pkg::MAX_SIDE)) ?
                bmv_pkg::SIDE_W'(bmv_pkg::MAX_SIDE) : lower_reg;
        n_eff = (length_reg > bmv_pkg::LEN_W'(bmv_pkg::MAX_LENGTH)) ?
                bmv_pkg::LEN_W'(bmv_pkg::MAX_LENGTH) : length_reg;
        k_max    = bmv_pkg::KW'(u_eff) + bmv_pkg::KW'(l_eff);
        row_last = (bmv_pkg::LEN_W'(row_reg) == (n_eff - 1'b1));
    end

    // Column of the current band term: j = row + upper - k, used only when in range.
    always_comb
    begin
        j = $signed(bmv_pkg::J_W'(row_reg)) + $signed(bmv_pkg::J_W'(u_eff))
            - $signed(bmv_pkg::J_W'(k_reg));
        term_ok = !j[bmv_pkg::J_W-1] && (j < $signed(bmv_pkg::J_W'(n_eff)));
    end

    // Input decode.
    always_comb
    begin
        in_fire = in_ch.valid && in_ch.ready;
        is_run  = (bmv_pkg::op_t'(in_ch.operation) == bmv_pkg::OP_RUN);
        pos_ok  = (bmv_pkg::LEN_W'(in_ch.position) < bmv_pkg::LEN_W'(bmv_pkg::MAX_LENGTH));
        brow_ok = (in_ch.band_row < bmv_pkg::BROW_W'(bmv_pkg::BAND_ROWS));
    end

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        case (state_reg)
            bmv_pkg::ST_IDLE:
            begin
                if (in_fire && is_run && (n_eff != '0))
                begin
                    state_next = bmv_pkg::ST_START;
                    row_next   = '0;
                    k_next     = '0;
                end
            end
            bmv_pkg::ST_START:
            begin
                if (out_free)
                begin
                    state_next = bmv_pkg::ST_ISSUE;
                end
            end
            bmv_pkg::ST_ISSUE:
            begin
                if (k_reg == k_max)
                begin
                    state_next = bmv_pkg::ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            bmv_pkg::ST_DRAIN:
            begin
                if (fin.valid)
                begin
                    k_next = '0;
                    if (row_last)
                    begin
                        state_next = bmv_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = bmv_pkg::ST_START;
                        row_next   = row_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = bmv_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake, issued term and memory requests.
    always_comb
    begin
        in_ch.ready = (state_reg == bmv_pkg::ST_IDLE);

        issue.valid    = (state_reg == bmv_pkg::ST_ISSUE);
        issue.first    = (k_reg == '0);
        issue.last     = (k_reg == k_max);
        issue.ok       = term_ok;
        issue.row      = row_reg;
        issue.last_row = row_last;

        mem = '0;

        // Band store: load writes, run reads.
        mem.band_we    = in_fire && (bmv_pkg::op_t'(in_ch.operation) == bmv_pkg::OP_BAND)
                         && brow_ok && pos_ok;
        mem.band_waddr = bmv_pkg::BAND_AW'(in_ch.band_row) *
                         bmv_pkg::BAND_AW'(bmv_pkg::MAX_LENGTH) +
                         bmv_pkg::BAND_AW'(in_ch.position);
        mem.band_wdata = in_ch.value;
        mem.band_re    = issue.valid && term_ok;
        mem.band_raddr = bmv_pkg::BAND_AW'(k_reg) * bmv_pkg::BAND_AW'(bmv_pkg::MAX_LENGTH) +
                         bmv_pkg::BAND_AW'(j[bmv_pkg::POS_W-1:0]);

        // Vector store.
        mem.vec_we    = in_fire && (bmv_pkg::op_t'(in_ch.operation) == bmv_pkg::OP_VECTOR)
                        && pos_ok;
        mem.vec_waddr = in_ch.position;
        mem.vec_wdata = in_ch.value;
        mem.vec_re    = issue.valid && term_ok;
        mem.vec_raddr = j[bmv_pkg::POS_W-1:0];

        // Accumulator store: loads and row write-back never coincide.
        if (fin.valid)
        begin
            mem.acc_we    = 1'b1;
            mem.acc_waddr = fin.row;
            mem.acc_wdata = fin.result;
        end
        else
        begin
            mem.acc_we    = in_fire && (bmv_pkg::op_t'(in_ch.operation) == bmv_pkg::OP_ACCUM)
                            && pos_ok;
            mem.acc_waddr = in_ch.position;
            mem.acc_wdata = in_ch.value;
        end
        mem.acc_re    = issue.valid && issue.first;
        mem.acc_raddr = row_reg;

        acc_ok = acc_ok_reg;
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmv_pkg::ST_IDLE;
            row_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= bmv_pkg::SIDE_W'(1);
            lower_reg  <= bmv_pkg::SIDE_W'(1);
            length_reg <= bmv_pkg::LEN_W'(bmv_pkg::MAX_LENGTH);
        end
        else if (cfg_we)
        begin
            case (bmv_pkg::cfg_reg_t'(cfg_index))
                bmv_pkg::REG_UPPER:  upper_reg  <= cfg_data[bmv_pkg::SIDE_W-1:0];
                bmv_pkg::REG_LOWER:  lower_reg  <= cfg_data[bmv_pkg::SIDE_W-1:0];
                bmv_pkg::REG_LENGTH: length_reg <= cfg_data[bmv_pkg::LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Written flags of the accumulator store; an unwritten entry reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= '0;
            acc_ok_reg  <= 1'b0;
        end
        else
        begin
            if (mem.acc_we)
            begin
                acc_vld_reg[mem.acc_waddr] <= 1'b1;
            end
            acc_ok_reg <= acc_vld_reg[mem.acc_raddr];
        end
    end

    // A finished row only arrives while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        fin.valid |-> (state_reg == bmv_pkg::ST_DRAIN))
        else $error("row finished outside drain");

    // Band steps advance by one per issue cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmv_pkg::ST_ISSUE) && (k_reg != k_max)
        |=> (k_reg == bmv_pkg::KW'($past(k_reg) + 1'b1)))
        else $error("band step skipped");

    // An in-range term always addresses a column inside the vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem.vec_re |-> (bmv_pkg::LEN_W'(mem.vec_raddr) < n_eff))
        else $error("vector read beyond length");

endmodule

`default_nettype wire

// ===== rtl/bmv_mac.sv =====
// Multiply-accumulate datapath: product register, wide row accumulator,
// rounding and saturation to Q16.16. Uses bmv_pkg.
`default_nettype none

module bmv_mac (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bmv_pkg::term_t                    issue,
    input  wire logic [bmv_pkg::DATA_W-1:0]        band_q,
    input  wire logic [bmv_pkg::DATA_W-1:0]        vec_q,
    input  wire logic [bmv_pkg::DATA_W-1:0]        acc_q,
    input  wire logic                              acc_ok,
    output bmv_pkg::fin_t                          fin
);

    localparam logic signed [bmv_pkg::ACC_W-1:0] ROUND =
        (bmv_pkg::FRAC_BITS > 0) ?
        (bmv_pkg::ACC_W'(1) << ((bmv_pkg::FRAC_BITS > 0) ? bmv_pkg::FRAC_BITS - 1 : 0)) :
        '0;

    bmv_pkg::term_t                         s1_reg, s2_reg, s3_reg;
    logic signed [bmv_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic signed [bmv_pkg::DATA_W-1:0]      base_reg, base_next;
    logic signed [bmv_pkg::ACC_W-1:0]       acc_reg, acc_next;

    logic signed [bmv_pkg::DATA_W-1:0]      a_s, x_s;
    logic signed [bmv_pkg::ACC_W-1:0]       shifted;
    logic [bmv_pkg::ACC_W-bmv_pkg::DATA_W:0] top_bits;
    logic                                   in_range;

    // Product stage: exact signed product of band entry and vector element.
    always_comb
    begin
        a_s = $signed(band_q);
        x_s = $signed(vec_q);
        if (s1_reg.ok)
        begin
            prod_next = a_s * x_s;
        end
        else
        begin
            prod_next = '0;
        end
        base_next = base_reg;
        if (s1_reg.valid && s1_reg.first)
        begin
            base_next = acc_ok ? $signed(acc_q) : '0;
        end
    end

    // Accumulate stage: the first term also brings the scaled base and the rounding bias.
    always_comb
    begin
        acc_next = acc_reg;
        if (s2_reg.valid)
        begin
            if (s2_reg.first)
            begin
                acc_next = (bmv_pkg::ACC_W'(base_reg) <<< bmv_pkg::FRAC_BITS) + ROUND +
                           bmv_pkg::ACC_W'(prod_reg);
            end
            else
            begin
                acc_next = acc_reg + bmv_pkg::ACC_W'(prod_reg);
            end
        end
    end

    // Round-shift and saturate the finished row.
    always_comb
    begin
        shifted  = acc_reg >>> bmv_pkg::FRAC_BITS;
        top_bits = shifted[bmv_pkg::ACC_W-1:bmv_pkg::DATA_W-1];
        in_range = (&top_bits) || !(|top_bits);

        fin.valid    = s3_reg.valid && s3_reg.last;
        fin.row      = s3_reg.row;
        fin.last_row = s3_reg.last_row;
        fin.sat      = !in_range;
        if (in_range)
        begin
            fin.result = shifted[bmv_pkg::DATA_W-1:0];
        end
        else if (shifted[bmv_pkg::ACC_W-1])
        begin
            fin.result = {1'b1, {(bmv_pkg::DATA_W-1){1'b0}}};
        end
        else
        begin
            fin.result = {1'b0, {(bmv_pkg::DATA_W-1){1'b1}}};
        end
    end

    // Pipeline tokens.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s1_reg <= issue;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
    end

    // Terms of two rows never overlap in the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.valid && s1_reg.first) |-> (!s2_reg.valid || s2_reg.last))
        else $error("rows overlap in accumulator");

    // The first term of a row is followed by terms of the same row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_reg.valid && !s2_reg.first) |-> (s3_reg.valid && (s3_reg.row == s2_reg.row)))
        else $error("accumulation lost its row");

endmodule

`default_nettype wire

// ===== rtl/banded_matrix_vector_product.sv =====
// Banded matrix-vector product y := sat(y + A*x), Q16.16, band storage by column.
// Load items are accepted back to back while idle. A run handles the rows in turn:
// per row a start state that waits for a free output slot, upper+lower+1 issued
// terms on the single multiply-accumulate unit, then a drain through its pipeline.
// Reset: configuration returns to 1/1/64, the accumulator store reads as zero through
// per-entry written flags (no clearing pass); band and vector stores are not cleared.
`default_nettype none

module banded_matrix_vector_product (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bmv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bmv_pkg::CFG_DATA_W-1:0]    cfg_data,
    bmv_in_if.sink                                 in_ch,
    bmv_out_if.source                              out_ch
);

    bmv_pkg::term_t                     issue;
    bmv_pkg::mem_req_t                  mem;
    bmv_pkg::fin_t                      fin;
    logic                               acc_ok;
    logic                               out_free;
    logic [bmv_pkg::DATA_W-1:0]         band_q, vec_q, acc_q;

    logic                               out_valid_reg, out_valid_next;
    logic [bmv_pkg::POS_W-1:0]          out_row_reg;
    logic signed [bmv_pkg::DATA_W-1:0]  out_result_reg;
    logic                               out_sat_reg;
    logic                               out_last_reg;

    // Sequencer.
    bmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_free  (out_free),
        .fin       (fin),
        .issue     (issue),
        .mem       (mem),
        .acc_ok    (acc_ok)
    );

    // Band store.
    bmv_ram #(.WIDTH(bmv_pkg::DATA_W), .DEPTH(bmv_pkg::BAND_DEPTH)) u_band_ram (
        .clk   (clk),
        .we    (mem.band_we),
        .waddr (mem.band_waddr),
        .wdata (mem.band_wdata),
        .re    (mem.band_re),
        .raddr (mem.band_raddr),
        .rdata (band_q)
    );

    // Vector store.
    bmv_ram #(.WIDTH(bmv_pkg::DATA_W), .DEPTH(bmv_pkg::MAX_LENGTH)) u_vec_ram (
        .clk   (clk),
        .we    (mem.vec_we),
        .waddr (mem.vec_waddr),
        .wdata (mem.vec_wdata),
        .re    (mem.vec_re),
        .raddr (mem.vec_raddr),
        .rdata (vec_q)
    );

    // Accumulator store.
    bmv_ram #(.WIDTH(bmv_pkg::DATA_W), .DEPTH(bmv_pkg::MAX_LENGTH)) u_acc_ram (
        .clk   (clk),
        .we    (mem.acc_we),
        .waddr (mem.acc_waddr),
        .wdata (mem.acc_wdata),
        .re    (mem.acc_re),
        .raddr (mem.acc_raddr),
        .rdata (acc_q)
    );

    // Multiply-accumulate datapath.
    bmv_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .band_q (band_q),
        .vec_q  (vec_q),
        .acc_q  (acc_q),
        .acc_ok (acc_ok),
        .fin    (fin)
    );

    // Output register: a row may start once the slot is empty or being transferred.
    always_comb
    begin
        out_free       = !out_valid_reg || out_ch.ready;
        out_valid_next = out_valid_reg;
        if (fin.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            out_row_reg    <= fin.row;
            out_result_reg <= fin.result;
            out_sat_reg    <= fin.sat;
            out_last_reg   <= fin.last_row;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.row_index = out_row_reg;
    assign out_ch.result    = out_result_reg;
    assign out_ch.saturated = out_sat_reg;
    assign out_ch.last      = out_last_reg;

    // A finished row never overwrites a result still waiting for transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        fin.valid |-> !out_valid_reg)
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire
